FILE: rtl/kds_pkg.sv
// ----------------------------------------------------------------------------
// kds_pkg
// Types, constants and key tables shared by the keyboard distance blocks.
// ----------------------------------------------------------------------------
package kds_pkg;

  localparam int DistW       = 12;    // pair distance, Q4.8
  localparam int SumW        = 24;    // distance sum, Q16.8
  localparam int SimW        = 16;    // similarity, Q0.16
  localparam int MaxPairsDef = 4096;
  localparam int QDepth      = 4;
  localparam int XqW         = 6;     // key x position in quarter keys
  localparam int DistTabN    = 256;

  // Bound on the pair distance, sqrt(9.5^2 + 3^2) in Q4.8.
  localparam logic [DistW-1:0] MaxDQ8 = 12'd2550;

  typedef struct packed {
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic       last_pair;
  } kds_in_t;

  typedef struct packed {
    logic [SimW-1:0] similarity;
    logic            overflow;
  } kds_out_t;

  // One classified pair as it travels from the front end to the accumulator.
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             last;
  } kds_pair_t;

  typedef logic [3:0] key_col_t;
  typedef logic [1:0] key_row_t;
  typedef key_col_t letter_col_tab_t [26];
  typedef key_row_t letter_row_tab_t [26];
  typedef logic [2:0] row_off_tab_t [4];
  typedef logic [DistW-1:0] dist_tab_t [DistTabN];

  // QWERTY column and row of letters a..z; the bottom-left key sits in column 0.
  localparam letter_col_tab_t LetterCol = '{
    4'd0, 4'd4, 4'd2, 4'd2, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7, 4'd6, 4'd7, 4'd8, 4'd6,
    4'd5, 4'd8, 4'd9, 4'd0, 4'd3, 4'd1, 4'd4, 4'd6, 4'd3, 4'd1, 4'd1, 4'd5, 4'd0};
  localparam letter_row_tab_t LetterRow = '{
    2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3,
    2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3};

  // Row stagger in quarter keys: 0, 0.5, 0.75 and 1.25 keys.
  localparam row_off_tab_t RowOffQ = '{3'd0, 3'd2, 3'd3, 3'd5};

  // Rounded distance for every (dy, dx) pair, evaluated at elaboration.
  // The entry at {dy, dx} is the rounded square root of 4096 * (dx^2 + 16 * dy^2).
  function automatic dist_tab_t build_dist_tab();
    dist_tab_t   tab;
    int unsigned n;
    int unsigned r;
    int unsigned b;
    for (int dy = 0; dy < 4; dy++) begin
      for (int dx = 0; dx < 64; dx++) begin
        n = 4096 * (dx * dx + 16 * dy * dy);
        r = 0;
        b = 32'h4000_0000;
        for (int s = 0; s < 16; s++) begin
          if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
          b = b >> 2;
        end
        if (n > r) begin
          r = r + 1;
        end
        tab[dy * 64 + dx] = DistW'(r);
      end
    end
    return tab;
  endfunction

  localparam dist_tab_t DistTab = build_dist_tab();

endpackage

FILE: rtl/kds_front.sv
// ----------------------------------------------------------------------------
// kds_front
// Classifies each character pair and looks up its key distance.
// ----------------------------------------------------------------------------
module kds_front import kds_pkg::*; (
  input  logic      key_layout_i,
  input  kds_in_t   pair_i,
  output kds_pair_t pair_o
);

  typedef struct packed {
    logic           valid;
    logic [XqW-1:0] xq;
    key_row_t       row;
  } key_pos_t;

  function automatic key_pos_t key_place(input logic [7:0] ch, input logic layout);
    key_pos_t   pos;
    logic [7:0] lc;
    logic [4:0] k;
    key_col_t   col;
    key_row_t   row;
    lc  = (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'h20 : ch;  // upper to lower case
    k   = 5'(lc - 8'h61);
    col = '0;
    row = '0;
    pos.valid = 1'b1;
    if (lc >= 8'h31 && lc <= 8'h39) begin
      col = 4'(lc - 8'h31);
    end else if (lc == 8'h30) begin
      col = 4'd9;
    end else if (lc >= 8'h61 && lc <= 8'h7A) begin
      // QWERTZ swaps the y and z keys.
      if (layout && k == 5'd24) begin
        k = 5'd25;
      end else if (layout && k == 5'd25) begin
        k = 5'd24;
      end
      col = LetterCol[k];
      row = LetterRow[k];
    end else begin
      pos.valid = 1'b0;
    end
    pos.xq  = {col, 2'b00} + XqW'(RowOffQ[row]);
    pos.row = row;
    return pos;
  endfunction

  key_pos_t       pos_a;
  key_pos_t       pos_b;
  logic [XqW-1:0] dx;
  key_row_t       dy;

  always_comb begin
    pos_a = key_place(pair_i.char_first, key_layout_i);
    pos_b = key_place(pair_i.char_second, key_layout_i);
    dx    = (pos_a.xq > pos_b.xq) ? pos_a.xq - pos_b.xq : pos_b.xq - pos_a.xq;
    dy    = (pos_a.row > pos_b.row) ? pos_a.row - pos_b.row : pos_b.row - pos_a.row;
    // A pair with a byte off the keyboard still counts but adds nothing.
    pair_o.distance = (pos_a.valid && pos_b.valid) ? DistTab[{dy, dx}] : '0;
    pair_o.last     = pair_i.last_pair;
  end

endmodule

FILE: rtl/kds_queue.sv
// ----------------------------------------------------------------------------
// kds_queue
// Short first-in first-out queue between the front end and the accumulator.
// ----------------------------------------------------------------------------
module kds_queue import kds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  kds_pair_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output kds_pair_t data_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  kds_pair_t       mem_q [QDepth];
  logic [PtrW-1:0] wptr_q;
  logic [PtrW-1:0] rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/kds_back.sv
// ----------------------------------------------------------------------------
// kds_back
// Accumulates pair distances and divides out the similarity on the last pair.
// ----------------------------------------------------------------------------
module kds_back import kds_pkg::*; #(
  parameter int MaxPairs = MaxPairsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  kds_pair_t q_data_i,
  output logic      q_pop_o,
  output kds_out_t  result_o,
  output logic      empty,
  input  logic      pop
);

  localparam int CntW     = $clog2(MaxPairs + 1);
  localparam int DenW     = DistW + CntW;
  localparam int CmpW     = (DenW > SumW) ? DenW : SumW;
  localparam int StepW    = $clog2(SimW);

  typedef enum logic [2:0] {
    S_ACC,
    S_MUL,
    S_CMP,
    S_DIV,
    S_PUT
  } state_e;

  state_e           state_q;
  logic [SumW-1:0]  sum_q;
  logic [CntW-1:0]  cnt_q;
  logic             sat_q;
  logic [SumW-1:0]  fsum_q;
  logic [CntW-1:0]  fcnt_q;
  logic             fsat_q;
  logic [DenW-1:0]  den_q;
  logic [DenW-1:0]  rem_q;
  logic [SimW-1:0]  quo_q;
  logic [StepW-1:0] step_q;
  kds_out_t         res_q;
  logic             out_valid_q;

  logic [SumW:0]    sum_ext;
  logic [SumW-1:0]  acc_sum;
  logic [CntW-1:0]  acc_cnt;
  logic             acc_sat;
  logic [CmpW-1:0]  fsum_ext;
  logic [CmpW-1:0]  den_ext;
  logic [CmpW-1:0]  diff;
  logic [DenW:0]    rem2;
  logic             quo_bit;

  always_comb begin
    sum_ext = {1'b0, sum_q} + (SumW + 1)'(q_data_i.distance);
    // A pair beyond the count limit is dropped and only marks the overflow.
    if (cnt_q == CntW'(MaxPairs)) begin
      acc_sum = sum_q;
      acc_cnt = cnt_q;
      acc_sat = 1'b1;
    end else begin
      acc_sum = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
      acc_cnt = cnt_q + 1'b1;
      acc_sat = sat_q;
    end
    fsum_ext = CmpW'(fsum_q);
    den_ext  = CmpW'(den_q);
    diff     = den_ext - fsum_ext;
    rem2     = {rem_q, 1'b0};
    quo_bit  = (rem2 >= {1'b0, den_q});
  end

  assign q_pop_o  = (state_q == S_ACC) && q_valid_i;
  assign result_o = res_q;
  assign empty    = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      sum_q       <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      fsum_q      <= '0;
      fcnt_q      <= '0;
      fsat_q      <= 1'b0;
      den_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // While loading, the new result replaces a popped one in the same cycle.
      if (pop && out_valid_q && state_q != S_PUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_ACC: begin
          if (q_valid_i) begin
            if (q_data_i.last) begin
              fsum_q  <= acc_sum;
              fcnt_q  <= acc_cnt;
              fsat_q  <= acc_sat;
              sum_q   <= '0;
              cnt_q   <= '0;
              sat_q   <= 1'b0;
              state_q <= S_MUL;
            end else begin
              sum_q <= acc_sum;
              cnt_q <= acc_cnt;
              sat_q <= acc_sat;
            end
          end
        end
        S_MUL: begin
          den_q   <= DenW'(MaxDQ8) * DenW'(fcnt_q);
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (den_q == '0 || fsum_ext >= den_ext) begin
            quo_q   <= '0;
            state_q <= S_PUT;
          end else if (fsum_q == '0) begin
            // A whole 1.0 saturates to the largest code.
            quo_q   <= '1;
            state_q <= S_PUT;
          end else begin
            rem_q   <= diff[DenW-1:0];
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // Restoring division, one fraction bit per cycle.
          rem_q  <= quo_bit ? DenW'(rem2 - {1'b0, den_q}) : rem2[DenW-1:0];
          quo_q  <= {quo_q[SimW-2:0], quo_bit};
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(SimW - 1)) begin
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (!out_valid_q || pop) begin
            res_q.similarity <= quo_q;
            res_q.overflow   <= fsat_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_ACC;
          end
        end
        default: begin
          state_q <= S_ACC;
        end
      endcase
    end
  end

endmodule

FILE: rtl/keyboard_distance_similarity.sv
// ----------------------------------------------------------------------------
// keyboard_distance_similarity
// Keyboard distance similarity of two strings fed as aligned character pairs.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// pair      in         push / full         pair_i   (char_first, char_second, last_pair)
// result    out        empty / pop         result_o (similarity, overflow)
// config    in         cfg_we_i            cfg_wdata_i (key_layout)
//
// A pair is classified and its distance looked up in the cycle it is pushed, then
// waits in a four-entry queue; the accumulator takes one pair per cycle except while it works on a last pair.
// A last pair stalls the accumulator for one multiply, one compare, 16 restoring
// divide steps and one load; a score of zero or full scale skips the divide. The
// load also waits while a result is unread, and the queue takes pairs until it
// fills. Reset clears all control state.
// ----------------------------------------------------------------------------
module keyboard_distance_similarity import kds_pkg::*; #(
  parameter int MaxPairs = MaxPairsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  kds_in_t  pair_i,
  input  logic     push,
  output logic     full,
  output kds_out_t result_o,
  output logic     empty,
  input  logic     pop
);

  logic      key_layout_q;
  kds_pair_t front_pair;
  kds_pair_t q_data;
  logic      q_valid;
  logic      q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_layout_q <= 1'b0;
    end else if (cfg_we_i) begin
      key_layout_q <= cfg_wdata_i;
    end
  end

  kds_front u_front (
    .key_layout_i (key_layout_q),
    .pair_i       (pair_i),
    .pair_o       (front_pair)
  );

  kds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_pair),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  kds_back #(
    .MaxPairs (MaxPairs)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .result_o  (result_o),
    .empty     (empty),
    .pop       (pop)
  );

  // The accumulator only takes pairs that are waiting in the queue.
  a_pop_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("accumulator took a pair from an empty queue");

  // After a last pair the accumulator is busy computing the score.
  a_last_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop && q_data.last |=> !q_pop)
    else $error("accumulator took a pair during the division");

  // A new result never lands while the previous one is still waiting.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("waiting result was lost or changed");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyboard_distance_similarity. Character pairs are
// pushed in random bursts and scored by an independent key-position model.
// Every result popped from the block is checked against the oldest predicted
// score. Layout switches happen only while the block is drained.
// ----------------------------------------------------------------------------
module testbench import kds_pkg::*;;

  // sqrt(9.5^2 + 3^2) keys in 1/256 key units: a bound on the pair distance.
  localparam int unsigned FullScaleDist = 2550;
  localparam int unsigned DistSumMax    = 24'hFF_FFFF;
  localparam int unsigned ItemsPerPhase = 220;

  typedef struct packed {
    kds_in_t  pair;
    logic     typed;
    kds_out_t want;
  } probe_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic     cfg_wdata_i = 1'b0;
  kds_in_t  pair_i      = '0;
  logic     push        = 1'b0;
  logic     full;
  kds_out_t result_o;
  logic     empty;
  logic     pop         = 1'b0;

  // Scoring state kept alongside the block.
  bit          layout_qwertz;
  int unsigned dist_total;
  int unsigned pairs_seen;
  bit          pairs_capped;

  kds_out_t expected_scores[$];
  int       mismatches;
  int       items_sent;
  int       burst_left;

  // Receiver stall pattern and the long hold-off.
  bit hold_req;
  int hold_left;
  int pop_mode;
  int pop_span;

  // Rows with a typed score hold the same or unmappable characters only, so
  // they give full similarity under either layout.
  probe_row_t probes [12] = '{
    '{'{"a", "a", 1'b1}, 1'b1, '{16'd65535, 1'b0}},
    '{'{"!", "q", 1'b1}, 1'b1, '{16'd65535, 1'b0}},
    '{'{8'hFF, 8'h80, 1'b1}, 1'b1, '{16'd65535, 1'b0}},
    '{'{"Z", "z", 1'b1}, 1'b1, '{16'd65535, 1'b0}},
    '{'{"y", "z", 1'b1}, 1'b0, '0},
    '{'{"1", "0", 1'b0}, 1'b0, '0},
    '{'{"p", "Z", 1'b0}, 1'b0, '0},
    '{'{" ", "M", 1'b1}, 1'b0, '0},
    '{'{"Q", "q", 1'b0}, 1'b0, '0},
    '{'{8'h00, "5", 1'b1}, 1'b1, '{16'd65535, 1'b0}},
    '{'{"m", "7", 1'b1}, 1'b0, '0},
    '{'{"x", "b", 1'b1}, 1'b0, '0}
  };

  keyboard_distance_similarity u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pair_i     (pair_i),
    .push       (push),
    .full       (full),
    .result_o   (result_o),
    .empty      (empty),
    .pop        (pop)
  );

  always #6 clk_i = ~clk_i;

  // Keys of one row in column order.
  function automatic string row_keys(input bit qwertz, input int r);
    case (r)
      0: return "1234567890";
      1: return qwertz ? "qwertzuiop" : "qwertyuiop";
      2: return "asdfghjkl";
      default: return qwertz ? "yxcvbnm" : "zxcvbnm";
    endcase
  endfunction

  // Position of a character in quarter keys across and whole rows down.
  function automatic bit key_spot(input logic [7:0] ch, input bit qwertz,
                                  output int xq, output int row);
    string      keys;
    logic [7:0] c;
    c = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
    xq = 0;
    row = 0;
    for (int r = 0; r < 4; r++) begin
      keys = row_keys(qwertz, r);
      for (int k = 0; k < keys.len(); k++) begin
        if (keys[k] == c) begin
          xq = 4 * k + ((r == 0) ? 0 : (r == 1) ? 2 : (r == 2) ? 3 : 5);
          row = r;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned rounded_root(input int unsigned n);
    int unsigned r;
    r = 0;
    for (int b = 12; b >= 0; b--) begin
      if ((r | (1 << b)) * (r | (1 << b)) <= n) begin
        r = r | (1 << b);
      end
    end
    // The remainder beyond r*r exceeds r exactly when sqrt(n) > r + 0.5.
    if (n > r * r + r) begin
      r++;
    end
    return r;
  endfunction

  // Advances the scoring state by one pair; returns 1 with the score on a last pair.
  function automatic bit score_pair(input kds_in_t it, output kds_out_t score);
    int                x1, y1, x2, y2;
    int unsigned       dx, dy;
    longint unsigned   denom, sim;
    score = '0;
    if (pairs_seen >= MaxPairsDef) begin
      pairs_capped = 1'b1;
    end else begin
      pairs_seen++;
      if (key_spot(it.char_first, layout_qwertz, x1, y1) &&
          key_spot(it.char_second, layout_qwertz, x2, y2)) begin
        dx = (x1 > x2) ? x1 - x2 : x2 - x1;
        dy = (y1 > y2) ? y1 - y2 : y2 - y1;
        dist_total += rounded_root(4096 * (dx * dx + 16 * dy * dy));
        if (dist_total > DistSumMax) begin
          dist_total = DistSumMax;
        end
      end
    end
    if (!it.last_pair) begin
      return 1'b0;
    end
    denom = longint'(FullScaleDist) * pairs_seen;
    sim = 0;
    if (denom != 0 && dist_total < denom) begin
      sim = (64'd65536 * (denom - dist_total)) / denom;
      if (sim > 65535) begin
        sim = 65535;
      end
    end
    score.similarity = sim[15:0];
    score.overflow = pairs_capped;
    dist_total = 0;
    pairs_seen = 0;
    pairs_capped = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1, 2: return 8'("0" + $urandom_range(9));
      3: return 8'("A" + $urandom_range(25));
      default: return 8'("a" + $urandom_range(25));
    endcase
  endfunction

  // Offers one item, holding it until accepted; the sender may idle between bursts.
  task automatic feed(input kds_in_t it, input bit typed, input kds_out_t want);
    int       gap;
    kds_out_t score;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    pair_i <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (score_pair(it, score)) begin
      expected_scores.push_back(typed ? want : score);
    end
  endtask

  task automatic send_string(input int len);
    for (int i = 0; i < len; i++) begin
      feed('{rand_char(), rand_char(), i == len - 1}, 1'b0, '0);
    end
  endtask

  // Stops offering items and waits for every outstanding score.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (expected_scores.size() != 0);
  endtask

  task automatic set_layout(input bit qwertz);
    drain();
    // Pairs without a result may still be inside the block.
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= qwertz;
    @(posedge clk_i);
    layout_qwertz = qwertz;
    cfg_we_i <= 1'b0;
  endtask

  // Result side: check the popped item, then choose the next pop.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_scores.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: sim %0d ovf %0d",
                     result_o.similarity, result_o.overflow);
          end
        end else if (result_o !== expected_scores[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("score mismatch: expected sim %0d ovf %0d, got sim %0d ovf %0d",
                     expected_scores[0].similarity, expected_scores[0].overflow,
                     result_o.similarity, result_o.overflow);
          end
          void'(expected_scores.pop_front());
        end else begin
          void'(expected_scores.pop_front());
        end
      end
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (pop_span == 0) begin
        pop_mode = $urandom_range(3);
        pop_span = $urandom_range(16, 96);
      end
      pop_span--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (pop_mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(1));
          2: pop <= ($urandom_range(3) == 0);
          default: pop <= (pop_span % 4) != 0;
        endcase
      end
    end
  end

  initial begin
    #24_000_000;
    $display("[keyboard_distance_similarity] ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, once per layout.
    for (int l = 0; l < 2; l++) begin
      set_layout(l[0]);
      foreach (probes[i]) begin
        feed(probes[i].pair, probes[i].typed, probes[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      set_layout(p == 1 || p == 2 || p == 4);
      items_sent = 0;
      if (p == 2) begin
        // Short strings against a stalled receiver fill the block up.
        hold_req = 1'b1;
        while (items_sent < ItemsPerPhase) begin
          send_string($urandom_range(1, 2));
        end
      end else begin
        while (items_sent < ItemsPerPhase) begin
          if (p == 3 && items_sent > ItemsPerPhase / 2 && items_sent < ItemsPerPhase / 2 + 8)
          begin
            drain();
          end
          send_string(($urandom_range(7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10));
        end
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[keyboard_distance_similarity] OK");
    end else begin
      $display("[keyboard_distance_similarity] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/kds_pkg.sv
rtl/kds_front.sv
rtl/kds_queue.sv
rtl/kds_back.sv
rtl/keyboard_distance_similarity.sv
tb/sv/testbench.sv
